/* rtl/ssm_pkg.sv */
// Shared types and constants of the state-space model step block.
package ssm_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ACT_STATES_W   = 4;
  localparam int unsigned ACT_INPUTS_W   = 2;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS = 1'b1;

  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_STATE = 2'd1,
    REQ_STEP  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MAT_A = 2'd0,
    MAT_B = 2'd1,
    MAT_C = 2'd2,
    MAT_D = 2'd3
  } matrix_sel_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE_X,
    ST_DRAIN,
    ST_ISSUE_Y,
    ST_WAIT_Y,
    ST_COMMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    OPD_STATE,
    OPD_NEXT,
    OPD_INPUT
  } opd_src_e;

  typedef struct packed {
    logic     vld;
    logic     first;
    logic     last;
    opd_src_e src;
  } issue_t;

  typedef struct packed {
    logic next_we;
    logic commit;
  } wb_t;

endpackage

/* rtl/state_space_model_step_top.sv */
// Top level of the fixed-point discrete-time linear state-space model step.
//
// Write transactions write one coefficient or one state element. A step
// transaction runs every product of x' = A*x + B*u and y = C*x' + D*u through
// one shared 32x32 multiply-accumulate unit fed from a coefficient memory with
// one registered read port, one product per cycle while the sequencer issues.
// The input stalls from the moment a step is taken until its result is
// presented, and longer while an earlier result still waits on a stalled
// receiver. After reset the coefficient memory is swept to zero, one entry
// per cycle, over all MAX_STATES*MAX_STATES + MAX_STATES*MAX_INPUTS +
// MAX_STATES + MAX_INPUTS entries (90 at the default sizes), and the first
// item is taken only after the sequencer has seen the sweep end and left its
// clear state. Configuration writes are accepted in any cycle and must only be
// made while no step is in progress.
module state_space_model_step_top import ssm_pkg::*; #(
  parameter int unsigned MAX_STATES = 8,
  parameter int unsigned MAX_INPUTS = 2,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [1:0]               matrix_sel_i,
  input  logic [2:0]               row_index_i,
  input  logic [2:0]               col_index_i,
  input  logic signed [DATA_W-1:0] write_value_i,
  input  logic signed [DATA_W-1:0] drive_input_i,
  input  logic signed [DATA_W-1:0] reference_input_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] plant_output_o,
  output logic                     saturated_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH = MAX_STATES * MAX_STATES + MAX_STATES * MAX_INPUTS
                                  + MAX_STATES + MAX_INPUTS;
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned IW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned KW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned NW  = $clog2(MAX_STATES + 1);
  localparam int unsigned KNW = $clog2(MAX_INPUTS + 1);
  localparam int unsigned TW  = $clog2(MAX_STATES + MAX_INPUTS);
  localparam int unsigned BASE_B = MAX_STATES * MAX_STATES;
  localparam int unsigned BASE_C = BASE_B + MAX_STATES * MAX_INPUTS;
  localparam int unsigned BASE_D = BASE_C + MAX_STATES;

  logic [ACT_STATES_W-1:0]  active_states_q;
  logic [ACT_INPUTS_W-1:0]  active_inputs_q;
  logic [NW-1:0]            n_act;
  logic [KNW-1:0]           ni_act;

  logic signed [DATA_W-1:0] state_q [MAX_STATES];
  logic signed [DATA_W-1:0] next_q  [MAX_STATES];
  logic signed [DATA_W-1:0] u_q     [MAX_INPUTS];
  logic                     sat_flag_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] plant_output_q;
  logic                     saturated_q;

  logic                     seq_ready;
  logic                     in_accept;
  logic                     step_start;
  logic                     coef_we;
  logic [AW-1:0]            coef_waddr;
  logic                     state_we;
  logic                     mem_busy;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] coef_rd;
  logic signed [DATA_W-1:0] opd_b;
  logic [TW-1:0]            opd_idx;
  issue_t                   issue;
  wb_t                      wb;
  logic [NW-1:0]            wb_idx;
  logic signed [DATA_W-1:0] sat_val;
  logic                     mac_sat;
  logic                     mac_done;
  logic                     out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_states_q <= ACT_STATES_W'(1);
      active_inputs_q <= ACT_INPUTS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_STATES: active_states_q <= cfg_data_i[ACT_STATES_W-1:0];
        CFG_ACTIVE_INPUTS: active_inputs_q <= cfg_data_i[ACT_INPUTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range counts are clamped into the supported shape.
  always_comb begin
    if (active_states_q == '0) begin
      n_act = NW'(1);
    end else if (int'(active_states_q) > MAX_STATES) begin
      n_act = NW'(MAX_STATES);
    end else begin
      n_act = NW'(active_states_q);
    end
    if (active_inputs_q == '0) begin
      ni_act = KNW'(1);
    end else if (int'(active_inputs_q) > MAX_INPUTS) begin
      ni_act = KNW'(MAX_INPUTS);
    end else begin
      ni_act = KNW'(active_inputs_q);
    end
  end

  assign in_stall_o = !seq_ready;
  assign in_accept  = in_valid_i && seq_ready;
  assign step_start = in_accept && (req_type_i == REQ_STEP);

  // Request decode; writes outside a matrix's shape are dropped.
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = '0;
    state_we   = 1'b0;
    if (in_accept) begin
      unique case (req_type_i)
        REQ_COEF: begin
          unique case (matrix_sel_i)
            MAT_A: begin
              coef_we    = (int'(row_index_i) < MAX_STATES) &&
                           (int'(col_index_i) < MAX_STATES);
              coef_waddr = AW'(int'(row_index_i) * MAX_STATES + int'(col_index_i));
            end
            MAT_B: begin
              coef_we    = (int'(row_index_i) < MAX_STATES) &&
                           (int'(col_index_i) < MAX_INPUTS);
              coef_waddr = AW'(BASE_B + int'(row_index_i) * MAX_INPUTS
                               + int'(col_index_i));
            end
            MAT_C: begin
              coef_we    = (row_index_i == '0) && (int'(col_index_i) < MAX_STATES);
              coef_waddr = AW'(BASE_C + int'(col_index_i));
            end
            MAT_D: begin
              coef_we    = (row_index_i == '0) && (int'(col_index_i) < MAX_INPUTS);
              coef_waddr = AW'(BASE_D + int'(col_index_i));
            end
            default: ;
          endcase
        end
        REQ_STATE: state_we = int'(row_index_i) < MAX_STATES;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        state_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_STATES; i++) begin
        if (state_we && (int'(row_index_i) == i)) begin
          state_q[i] <= write_value_i;
        end else if (wb.commit && (i < int'(n_act))) begin
          state_q[i] <= next_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb.next_we) begin
      next_q[wb_idx[IW-1:0]] <= sat_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_start) begin
      for (int k = 0; k < MAX_INPUTS; k++) begin
        if (k == 0) begin
          u_q[k] <= drive_input_i;
        end else if ((k == 1) && (int'(ni_act) >= 2)) begin
          u_q[k] <= reference_input_i;
        end else begin
          u_q[k] <= '0;
        end
      end
    end
  end

  always_comb begin
    unique case (issue.src)
      OPD_STATE: opd_b = state_q[opd_idx[IW-1:0]];
      OPD_NEXT:  opd_b = next_q[opd_idx[IW-1:0]];
      OPD_INPUT: opd_b = u_q[opd_idx[KW-1:0]];
      default:   opd_b = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_flag_q <= 1'b0;
    end else if (step_start) begin
      sat_flag_q <= 1'b0;
    end else if (wb.next_we && mac_sat) begin
      sat_flag_q <= 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb.commit) begin
      plant_output_q <= sat_val;
      saturated_q    <= sat_flag_q || mac_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plant_output_o = plant_output_q;
  assign saturated_o    = saturated_q;

  ssm_coef_mem #(
    .DEPTH (DEPTH)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (write_value_i),
    .raddr_i (rd_addr),
    .rdata_o (coef_rd),
    .busy_o  (mem_busy)
  );

  ssm_seq #(
    .MAX_STATES (MAX_STATES),
    .MAX_INPUTS (MAX_INPUTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_i     (mem_busy),
    .start_i    (step_start),
    .n_i        (n_act),
    .ni_i       (ni_act),
    .done_i     (mac_done),
    .out_free_i (out_free),
    .ready_o    (seq_ready),
    .issue_o    (issue),
    .raddr_o    (rd_addr),
    .opd_idx_o  (opd_idx),
    .wb_o       (wb),
    .wb_idx_o   (wb_idx)
  );

  ssm_mac #(
    .MAX_STATES (MAX_STATES),
    .MAX_INPUTS (MAX_INPUTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .coef_i    (coef_rd),
    .opd_i     (opd_b),
    .sat_val_o (sat_val),
    .sat_o     (mac_sat),
    .done_o    (mac_done)
  );

endmodule

/* rtl/ssm_coef_mem.sv */
// Coefficient memory for A, B, C and D with a clearing pass after reset.
module ssm_coef_mem import ssm_pkg::*; #(
  parameter int unsigned DEPTH = 90,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0] rdata_o,
  output logic                     busy_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     clr_addr_q;
  logic              busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // The clearing pass owns the write port until every entry holds zero.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

/* rtl/ssm_mac.sv */
// Shared multiply-accumulate unit with floor scaling and 32-bit saturation.
module ssm_mac import ssm_pkg::*; #(
  parameter int unsigned MAX_STATES = 8,
  parameter int unsigned MAX_INPUTS = 2,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  issue_t                   issue_i,
  input  logic signed [DATA_W-1:0] coef_i,
  input  logic signed [DATA_W-1:0] opd_i,
  output logic signed [DATA_W-1:0] sat_val_o,
  output logic                     sat_o,
  output logic                     done_o
);

  localparam int unsigned PROD_W = 2 * DATA_W - FRAC_BITS;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_STATES + MAX_INPUTS);

  logic                       vld1_q, first1_q, last1_q;
  logic                       vld2_q, first2_q, last2_q;
  logic                       done_q;
  logic signed [DATA_W-1:0]   b_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       pos_ovf, neg_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q   <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      vld2_q   <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      vld1_q   <= issue_i.vld;
      first1_q <= issue_i.first;
      last1_q  <= issue_i.last;
      vld2_q   <= vld1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= vld2_q && last2_q;
    end
  end

  // The coefficient arrives from the registered memory read alongside b_q.
  always_ff @(posedge clk_i) begin
    b_q    <= opd_i;
    prod_q <= coef_i * b_q;
    acc_q  <= acc_d;
  end

  // Arithmetic shift of the exact product rounds toward minus infinity.
  always_comb begin
    prod_sh  = prod_q >>> FRAC_BITS;
    prod_ext = {{(ACC_W - PROD_W){prod_sh[PROD_W-1]}}, prod_sh[PROD_W-1:0]};
    if (vld2_q) begin
      acc_d = (first2_q ? '0 : acc_q) + prod_ext;
    end else begin
      acc_d = acc_q;
    end
  end

  always_comb begin
    pos_ovf = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:DATA_W-1]);
    neg_ovf = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:DATA_W-1]);
    if (pos_ovf) begin
      sat_val_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_val_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val_o = acc_q[DATA_W-1:0];
    end
    sat_o = pos_ovf || neg_ovf;
  end

  assign done_o = done_q;

endmodule

/* rtl/ssm_seq.sv */
// Sequencer that walks the matrix products of one step through the shared unit.
module ssm_seq import ssm_pkg::*; #(
  parameter int unsigned MAX_STATES = 8,
  parameter int unsigned MAX_INPUTS = 2,
  localparam int unsigned DEPTH = MAX_STATES * MAX_STATES + MAX_STATES * MAX_INPUTS
                                  + MAX_STATES + MAX_INPUTS,
  localparam int unsigned AW  = $clog2(DEPTH),
  localparam int unsigned NW  = $clog2(MAX_STATES + 1),
  localparam int unsigned KNW = $clog2(MAX_INPUTS + 1),
  localparam int unsigned TW  = $clog2(MAX_STATES + MAX_INPUTS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           busy_i,
  input  logic           start_i,
  input  logic [NW-1:0]  n_i,
  input  logic [KNW-1:0] ni_i,
  input  logic           done_i,
  input  logic           out_free_i,
  output logic           ready_o,
  output issue_t         issue_o,
  output logic [AW-1:0]  raddr_o,
  output logic [TW-1:0]  opd_idx_o,
  output wb_t            wb_o,
  output logic [NW-1:0]  wb_idx_o
);

  localparam int unsigned TCW = $clog2(MAX_STATES + MAX_INPUTS + 1);
  localparam logic [AW-1:0] BASE_B = AW'(MAX_STATES * MAX_STATES);
  localparam logic [AW-1:0] BASE_C = AW'(MAX_STATES * MAX_STATES + MAX_STATES * MAX_INPUTS);
  localparam logic [AW-1:0] BASE_D = AW'(MAX_STATES * MAX_STATES + MAX_STATES * MAX_INPUTS
                                         + MAX_STATES);

  seq_state_e     state_q, state_d;
  logic [NW-1:0]  row_q, row_d;
  logic [NW-1:0]  wb_q, wb_d;
  logic [TW-1:0]  term_q, term_d;
  logic [AW-1:0]  a_base_q, a_base_d;
  logic [AW-1:0]  b_base_q, b_base_d;

  logic [TCW-1:0] terms_total;
  logic           x_term;
  logic           last_term;
  logic           row_last;
  logic           issuing;
  logic [TW-1:0]  in_k;

  assign terms_total = TCW'(n_i) + TCW'(ni_i);
  assign x_term      = TCW'(term_q) < TCW'(n_i);
  assign last_term   = TCW'(term_q) == (terms_total - TCW'(1));
  assign row_last    = row_q == (n_i - NW'(1));
  assign issuing     = (state_q == ST_ISSUE_X) || (state_q == ST_ISSUE_Y);
  assign in_k        = term_q - TW'(n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      row_q    <= '0;
      wb_q     <= '0;
      term_q   <= '0;
      a_base_q <= '0;
      b_base_q <= BASE_B;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      wb_q     <= wb_d;
      term_q   <= term_d;
      a_base_q <= a_base_d;
      b_base_q <= b_base_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!busy_i) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_ISSUE_X;
      end
      ST_ISSUE_X: begin
        if (last_term && row_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // The output row reads the new state, so every state row must be back.
        if (wb_q == n_i) state_d = ST_ISSUE_Y;
      end
      ST_ISSUE_Y: begin
        if (last_term) state_d = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (done_i) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Row, term and write-back counters.
  always_comb begin
    row_d    = row_q;
    wb_d     = wb_q;
    term_d   = term_q;
    a_base_d = a_base_q;
    b_base_d = b_base_q;
    if (state_q == ST_IDLE) begin
      row_d    = '0;
      wb_d     = '0;
      term_d   = '0;
      a_base_d = '0;
      b_base_d = BASE_B;
    end else begin
      if (issuing) begin
        term_d = last_term ? '0 : term_q + TW'(1);
      end
      if ((state_q == ST_ISSUE_X) && last_term) begin
        row_d    = row_q + NW'(1);
        a_base_d = a_base_q + AW'(MAX_STATES);
        b_base_d = b_base_q + AW'(MAX_INPUTS);
      end
      if (done_i && (wb_q != n_i)) begin
        wb_d = wb_q + NW'(1);
      end
    end
  end

  // Outputs.
  always_comb begin
    ready_o       = state_q == ST_IDLE;
    issue_o.vld   = issuing;
    issue_o.first = term_q == '0;
    issue_o.last  = last_term;
    if (!x_term) begin
      issue_o.src = OPD_INPUT;
    end else if (state_q == ST_ISSUE_Y) begin
      issue_o.src = OPD_NEXT;
    end else begin
      issue_o.src = OPD_STATE;
    end
    if (state_q == ST_ISSUE_Y) begin
      raddr_o = x_term ? BASE_C + AW'(term_q) : BASE_D + AW'(in_k);
    end else begin
      raddr_o = x_term ? a_base_q + AW'(term_q) : b_base_q + AW'(in_k);
    end
    opd_idx_o    = x_term ? term_q : in_k;
    wb_o.next_we = done_i && (wb_q != n_i);
    wb_o.commit  = (state_q == ST_COMMIT) && out_free_i;
    wb_idx_o     = wb_q;
  end

  a_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (state_q == ST_ISSUE_X || state_q == ST_DRAIN || state_q == ST_WAIT_Y))
    else $error("Accumulator result arrived outside a step.");

  a_wb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CLEAR) |-> wb_q <= n_i)
    else $error("More state rows written back than are active.");

  a_y_after_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_ISSUE_Y) |-> wb_q == n_i)
    else $error("Output row started before all state rows were written.");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE && !busy_i))
    else $error("Step started while the sequencer was busy.");

endmodule
